// ===== rtl/core/pbac_pkg.sv =====
// ----------------------------------------------------------------------------
// pbac_pkg
// Shared types and codes for the PCI BAR access check unit.
// ----------------------------------------------------------------------------
package pbac_pkg;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_WIDTH    = 3'd1,
		ST_ZERO_COUNT   = 3'd2,
		ST_CONFIG_RANGE = 3'd3,
		ST_BAD_BAR      = 3'd4,
		ST_WINDOW_RANGE = 3'd5
	} pbac_status_t;

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	localparam logic [1:0] SPACE_CFG = 2'd0;

	// width code: [1:0] log2 of unit, [3:2] == 01 is FIFO, above 11 invalid
	localparam logic [3:0] WCODE_MAX  = 4'd11;
	localparam logic [1:0] WCODE_FIFO = 2'b01;

	typedef struct packed {
		logic        command;
		logic [1:0]  space;
		logic        write;
		logic [2:0]  bar_index;
		logic [63:0] offset;
		logic [3:0]  width_code;
		logic [31:0] count;
	} pbac_req_t;

	typedef struct packed {
		pbac_status_t status;
		logic [63:0]  address;
		logic         tbl_we;
	} pbac_res_t;

endpackage

// ===== rtl/core/pbac_access_check.sv =====
// ----------------------------------------------------------------------------
// pbac_access_check
// Width decode, config-space range check, BAR window check and translation.
// ----------------------------------------------------------------------------
module pbac_access_check #(
	parameter int NUM_BARS           = 6,
	parameter int CONFIG_SPACE_BYTES = 4096
) (
	input  pbac_pkg::pbac_req_t req,
	input  logic [63:0]         win_base,
	input  logic [63:0]         win_size,
	output logic                bar_ok,
	output pbac_pkg::pbac_res_t res
);
	import pbac_pkg::*;

	localparam int CFG_W = $clog2(CONFIG_SPACE_BYTES + 1);

	logic [1:0]       unit_sh;
	logic [3:0]       unit;
	logic             is_fifo;
	logic             bad_width;
	logic             cfg_off_hi;
	logic [CFG_W-1:0] cfg_left;
	logic [CFG_W-1:0] cfg_units;
	logic             cfg_over;
	logic [34:0]      span;
	logic [65:0]      win_end;
	logic             win_over;
	logic [64:0]      sum;

	always_comb begin
		unit_sh   = req.width_code[1:0];
		unit      = 4'd1 << unit_sh;
		is_fifo   = (req.width_code[3:2] == WCODE_FIFO);
		bad_width = (req.width_code > WCODE_MAX);
		bar_ok    = ({1'b0, req.bar_index} < 4'(NUM_BARS));

		// units left in config space after the offset
		cfg_off_hi = (req.offset >= 64'(CONFIG_SPACE_BYTES));
		cfg_left   = CFG_W'(CONFIG_SPACE_BYTES) - req.offset[CFG_W-1:0];
		cfg_units  = cfg_left >> unit_sh;
		cfg_over   = cfg_off_hi || (req.count > 32'(cfg_units));

		// offset + span <= size covers both unit > size and span > size
		span     = is_fifo ? 35'(unit) : (35'(req.count) << unit_sh);
		win_end  = {2'b00, req.offset} + {31'd0, span};
		win_over = (win_end > {2'b00, win_size});
		sum      = {1'b0, win_base} + {1'b0, req.offset};
	end

	always_comb begin
		res.status  = ST_OK;
		res.address = '0;
		res.tbl_we  = 1'b0;
		if (req.command == CMD_LOAD) begin
			if (bar_ok) begin
				res.tbl_we = 1'b1;
			end else begin
				res.status = ST_BAD_BAR;
			end
		end else if (bad_width) begin
			res.status = ST_BAD_WIDTH;
		end else if (req.count == 32'd0) begin
			res.status = ST_ZERO_COUNT;
		end else if (req.space == SPACE_CFG) begin
			if (req.bar_index != 3'd0) begin
				res.status = ST_BAD_BAR;
			end else if (cfg_over) begin
				res.status = ST_CONFIG_RANGE;
			end else begin
				res.address = req.offset;
			end
		end else if (!bar_ok) begin
			res.status = ST_BAD_BAR;
		end else if (win_over || sum[64]) begin
			res.status = ST_WINDOW_RANGE;
		end else begin
			res.address = sum[63:0];
		end
	end

endmodule

// ===== rtl/core/pci_bar_access_check_unit.sv =====
// ----------------------------------------------------------------------------
// pci_bar_access_check_unit
// Checks PCI accesses against a BAR table and translates them; load words
// fill the table.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid, in_stall | command space write bar_index offset
//          |                    | width_code count bar_base_in bar_size_in
//  out     | out_valid,out_stall| status address write_out space_out
//          |                    | width_out count_out
//
//  One word per cycle sustained while out_stall is low; a word taken into the
//  input register moves into the result register once the result register is
//  free to take it, and its result shows from there.
//  The BAR table is written as a load word leaves the input register, so the
//  next word already sees it.
//  Reset clears the table (every window rejects) and both valid flags.
//  in_stall rises only while both registers hold words and out_stall is high.
// ----------------------------------------------------------------------------
module pci_bar_access_check_unit #(
	parameter int NUM_BARS           = 6,
	parameter int CONFIG_SPACE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [1:0]  space,
	input  logic        write,
	input  logic [2:0]  bar_index,
	input  logic [63:0] offset,
	input  logic [3:0]  width_code,
	input  logic [31:0] count,
	input  logic [63:0] bar_base_in,
	input  logic [63:0] bar_size_in,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [63:0] address,
	output logic        write_out,
	output logic [1:0]  space_out,
	output logic [3:0]  width_out,
	output logic [31:0] count_out
);
	import pbac_pkg::*;

	localparam int IDX_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;

	pbac_req_t   req_s1;
	logic [63:0] base_in_s1;
	logic [63:0] size_in_s1;
	logic        valid_s1;

	logic [63:0] base_q [NUM_BARS];
	logic [63:0] size_q [NUM_BARS];

	logic        out_free;
	logic        adv_s1;
	logic        take_in;
	logic        bar_ok;
	logic [IDX_W-1:0] rd_idx;
	logic [63:0] rd_base;
	logic [63:0] rd_size;
	pbac_res_t   res;

	assign out_free = !out_valid || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1.command    <= command;
			req_s1.space      <= space;
			req_s1.write      <= write;
			req_s1.bar_index  <= bar_index;
			req_s1.offset     <= offset;
			req_s1.width_code <= width_code;
			req_s1.count      <= count;
			base_in_s1        <= bar_base_in;
			size_in_s1        <= bar_size_in;
		end
	end

	assign rd_idx  = req_s1.bar_index[IDX_W-1:0];
	assign rd_base = bar_ok ? base_q[rd_idx] : 64'd0;
	assign rd_size = bar_ok ? size_q[rd_idx] : 64'd0;

	pbac_access_check #(
		.NUM_BARS           (NUM_BARS),
		.CONFIG_SPACE_BYTES (CONFIG_SPACE_BYTES)
	) u_check (
		.req      (req_s1),
		.win_base (rd_base),
		.win_size (rd_size),
		.bar_ok   (bar_ok),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BARS; i++) begin
				base_q[i] <= '0;
				size_q[i] <= '0;
			end
		end else if (adv_s1 && res.tbl_we) begin
			base_q[rd_idx] <= base_in_s1;
			size_q[rd_idx] <= size_in_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status    <= res.status;
			address   <= res.address;
			write_out <= req_s1.write;
			space_out <= req_s1.space;
			width_out <= req_s1.width_code;
			count_out <= req_s1.count;
		end
	end

endmodule

// ===== rtl/core/pbac_checker.sv =====
// ----------------------------------------------------------------------------
// pbac_checker
// Port-level checks for the PCI BAR access check unit.
// ----------------------------------------------------------------------------
module pbac_checker #(
	parameter int CONFIG_SPACE_BYTES = 4096
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [63:0] address,
	input logic [1:0]  space_out
);
	import pbac_pkg::*;

	// held result word must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(address))
		else $error("result word changed while stalled");

	// back-pressure only when the result register is full and blocked
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> address == 64'd0)
		else $error("failed access carries an address");

	a_cfg_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && space_out == SPACE_CFG
		|-> address < 64'(CONFIG_SPACE_BYTES))
		else $error("config address outside config space");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_WINDOW_RANGE)
		else $error("undefined status code");

endmodule

bind pci_bar_access_check_unit pbac_checker #(
	.CONFIG_SPACE_BYTES (CONFIG_SPACE_BYTES)
) u_pbac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.address   (address),
	.space_out (space_out)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCI BAR access check unit. Access and BAR load
// words go through the valid/stall input; outside the back-to-back test both
// sides idle at random. Each result is compared field by field with the
// oldest translation that the bench computed itself when the word was driven.
// ----------------------------------------------------------------------------
module tb_top;
	import pbac_pkg::*;

	localparam int NUM_BARS     = 6;
	localparam int CFG_BYTES    = 4096;
	localparam int DRAIN_CYCLES = 8;
	localparam int STUCK_LIMIT  = 1000;

	localparam logic [1:0] SPACE_MEM    = 2'd1;
	localparam logic [1:0] SPACE_IO     = 2'd2;
	localparam logic [1:0] SPACE_UNUSED = 2'd3;

	localparam logic [3:0] WC_BYTE       = 4'd0;
	localparam logic [3:0] WC_DWORD      = 4'd2;
	localparam logic [3:0] WC_QWORD      = 4'd3;
	localparam logic [3:0] WC_FIFO_DWORD = 4'd6;
	localparam logic [3:0] WC_FILL_BYTE  = 4'd8;
	localparam logic [3:0] WC_BAD_LOW    = 4'd12;
	localparam logic [3:0] WC_BAD_HIGH   = 4'd15;

	typedef struct {
		logic        command;
		logic [1:0]  space;
		logic        write;
		logic [2:0]  bar_index;
		logic [63:0] offset;
		logic [3:0]  width_code;
		logic [31:0] count;
		logic [63:0] ld_base;
		logic [63:0] ld_size;
	} access_word_t;

	typedef struct {
		pbac_status_t status;
		logic [63:0]  address;
		logic         write;
		logic [1:0]   space;
		logic [3:0]   width;
		logic [31:0]  count;
	} access_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [1:0]  space = '0;
	logic        write = 1'b0;
	logic [2:0]  bar_index = '0;
	logic [63:0] offset = '0;
	logic [3:0]  width_code = '0;
	logic [31:0] count = '0;
	logic [63:0] bar_base_in = '0;
	logic [63:0] bar_size_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [63:0] address;
	logic        write_out;
	logic [1:0]  space_out;
	logic [3:0]  width_out;
	logic [31:0] count_out;

	logic [63:0]    bar_base_tbl [NUM_BARS];
	logic [63:0]    bar_size_tbl [NUM_BARS];
	access_result_t pending_results [$];
	int             mismatch_count = 0;
	int             stuck_cycles = 0;
	bit             gaps_on = 1'b1;

	pci_bar_access_check_unit #(
		.NUM_BARS(NUM_BARS),
		.CONFIG_SPACE_BYTES(CFG_BYTES)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .space(space), .write(write), .bar_index(bar_index),
		.offset(offset), .width_code(width_code), .count(count),
		.bar_base_in(bar_base_in), .bar_size_in(bar_size_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address), .write_out(write_out),
		.space_out(space_out), .width_out(width_out), .count_out(count_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the result of one word and applies a load to the shadow table.
	function automatic access_result_t translate_access(input access_word_t w);
		access_result_t r;
		logic [63:0] unit, span, sz, bs;
		r.status  = ST_OK;
		r.address = '0;
		r.write   = w.write;
		r.space   = w.space;
		r.width   = w.width_code;
		r.count   = w.count;
		if (w.command == CMD_LOAD) begin
			if (w.bar_index < NUM_BARS) begin
				bar_base_tbl[w.bar_index] = w.ld_base;
				bar_size_tbl[w.bar_index] = w.ld_size;
			end else begin
				r.status = ST_BAD_BAR;
			end
			return r;
		end
		if (w.width_code > WCODE_MAX) begin
			r.status = ST_BAD_WIDTH;
			return r;
		end
		if (w.count == 0) begin
			r.status = ST_ZERO_COUNT;
			return r;
		end
		unit = 64'd1 << w.width_code[1:0];
		if (w.space == SPACE_CFG) begin
			if (w.bar_index != 0)
				r.status = ST_BAD_BAR;
			else if (w.offset >= CFG_BYTES ||
					64'(w.count) > (64'(CFG_BYTES) - w.offset) / unit)
				r.status = ST_CONFIG_RANGE;
			else
				r.address = w.offset;
			return r;
		end
		if (w.bar_index >= NUM_BARS) begin
			r.status = ST_BAD_BAR;
			return r;
		end
		sz = bar_size_tbl[w.bar_index];
		bs = bar_base_tbl[w.bar_index];
		// FIFO codes touch a single unit whatever the count
		span = (w.width_code[3:2] == WCODE_FIFO) ? unit : unit * 64'(w.count);
		if (unit > sz || span > sz || w.offset > sz - span || bs > ~64'd0 - w.offset)
			r.status = ST_WINDOW_RANGE;
		else
			r.address = bs + w.offset;
		return r;
	endfunction

	function automatic access_word_t make_access(input logic [1:0] sp, input logic wr,
			input logic [2:0] bar, input logic [63:0] off, input logic [3:0] code,
			input logic [31:0] cnt);
		access_word_t w;
		w.command    = CMD_ACCESS;
		w.space      = sp;
		w.write      = wr;
		w.bar_index  = bar;
		w.offset     = off;
		w.width_code = code;
		w.count      = cnt;
		w.ld_base    = '0;
		w.ld_size    = '0;
		return w;
	endfunction

	function automatic access_word_t make_load(input logic [2:0] bar,
			input logic [63:0] base, input logic [63:0] sz);
		access_word_t w;
		w = make_access(SPACE_MEM, 1'b0, bar, '0, WC_BYTE, 32'd1);
		w.command = CMD_LOAD;
		w.ld_base = base;
		w.ld_size = sz;
		return w;
	endfunction

	// Mostly well-formed accesses into loaded windows, some config accesses, some loads, some noise.
	function automatic access_word_t random_word();
		access_word_t w;
		int pick;
		logic [63:0] sz;
		pick = $urandom_range(0, 99);
		w = make_access(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
			3'($urandom_range(0, NUM_BARS - 1)), '0, 4'($urandom_range(0, WCODE_MAX)),
			32'($urandom_range(1, 16)));
		if (pick < 12) begin
			w.command   = CMD_LOAD;
			w.bar_index = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: w.ld_size = 64'd1 << $urandom_range(2, 24);
				1: w.ld_size = 64'($urandom_range(0, 16));
				2: w.ld_size = {$urandom, $urandom};
				default: w.ld_size = 64'h1000;
			endcase
			w.ld_base = {$urandom, $urandom};
			if ($urandom_range(0, 3) != 0)
				w.ld_base &= 64'h0000_ffff_ffff_f000;
		end else if (pick < 22) begin
			w.command    = 1'($urandom_range(0, 1));
			w.space      = 2'($urandom_range(0, 3));
			w.bar_index  = 3'($urandom_range(0, 7));
			w.offset     = {$urandom, $urandom};
			w.width_code = 4'($urandom_range(0, 15));
			w.count      = $urandom;
			w.ld_base    = {$urandom, $urandom};
			w.ld_size    = {$urandom, $urandom};
		end else if (pick < 40) begin
			w.space     = SPACE_CFG;
			w.bar_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
			w.offset    = 64'($urandom_range(0, CFG_BYTES + 100));
			w.count     = 32'($urandom_range(1, 600));
		end else begin
			sz = bar_size_tbl[w.bar_index];
			w.offset = (sz == 0) ? 64'($urandom_range(0, 16)) : {$urandom, $urandom} % sz;
			if (w.width_code[3:2] == WCODE_FIFO && $urandom_range(0, 1) == 1)
				w.count = $urandom;
		end
		return w;
	endfunction

	task automatic send_word(input access_word_t w);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		command     <= w.command;
		space       <= w.space;
		write       <= w.write;
		bar_index   <= w.bar_index;
		offset      <= w.offset;
		width_code  <= w.width_code;
		count       <= w.count;
		bar_base_in <= w.ld_base;
		bar_size_in <= w.ld_size;
		pending_results.push_back(translate_access(w));
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_reset_windows();
		// table is empty after reset, so every window rejects
		send_word(make_access(SPACE_MEM, 1'b0, 3'd0, 64'd0, WC_BYTE, 32'd1));
	endtask

	task automatic test_bar_loads();
		send_word(make_load(3'd0, 64'h0000_0000_f000_0000, 64'h1000));
		send_word(make_load(3'd1, 64'h0000_0001_0000_0000, 64'h10_0000));
		send_word(make_load(3'd2, 64'd0, 64'd4));
		send_word(make_load(3'd3, 64'hffff_ffff_ffff_f000, 64'h1_0000));
		send_word(make_load(3'd4, 64'h8000, 64'h100));
		send_word(make_load(3'd5, ~64'd0, ~64'd0));
		send_word(make_load(3'd7, 64'h1234, 64'h1000));
	endtask

	task automatic test_width_and_count();
		send_word(make_access(SPACE_MEM, 1'b1, 3'd1, 64'd0, WC_BAD_LOW, 32'd1));
		send_word(make_access(SPACE_CFG, 1'b0, 3'd0, 64'd0, WC_BAD_HIGH, 32'd0));
		send_word(make_access(SPACE_MEM, 1'b0, 3'd1, 64'd0, WC_DWORD, 32'd0));
	endtask

	task automatic test_config_space();
		send_word(make_access(SPACE_CFG, 1'b0, 3'd0, 64'd0, WC_BYTE, 32'd4096));
		send_word(make_access(SPACE_CFG, 1'b1, 3'd0, 64'd4095, WC_BYTE, 32'd1));
		send_word(make_access(SPACE_CFG, 1'b0, 3'd0, 64'd4096, WC_BYTE, 32'd1));
		send_word(make_access(SPACE_CFG, 1'b0, 3'd0, 64'd4092, WC_QWORD, 32'd1));
		send_word(make_access(SPACE_CFG, 1'b0, 3'd1, 64'd0, WC_BYTE, 32'd1));
		send_word(make_access(SPACE_CFG, 1'b0, 3'd0, ~64'd0, WC_BYTE, ~32'd0));
	endtask

	task automatic test_window_checks();
		send_word(make_access(SPACE_MEM, 1'b1, 3'd0, 64'hffc, WC_DWORD, 32'd1));
		send_word(make_access(SPACE_MEM, 1'b0, 3'd0, 64'd0, WC_FIFO_DWORD, ~32'd0));
		// span wider than the window must not wrap past the check
		send_word(make_access(SPACE_MEM, 1'b0, 3'd0, 64'd0, WC_QWORD, ~32'd0));
		send_word(make_access(SPACE_IO, 1'b0, 3'd2, 64'd0, WC_QWORD, 32'd1));
		send_word(make_access(SPACE_MEM, 1'b0, 3'd3, 64'h1000, WC_BYTE, 32'd1));
		send_word(make_access(SPACE_UNUSED, 1'b1, 3'd4, 64'hff, WC_FILL_BYTE, 32'd1));
		send_word(make_access(SPACE_MEM, 1'b1, 3'd5, 64'd0, WC_BYTE, 32'd1));
		send_word(make_access(SPACE_IO, 1'b0, 3'd6, 64'd0, WC_BYTE, 32'd1));
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n) send_word(random_word());
	endtask

	task automatic test_drain_pause();
		repeat (20) send_word(random_word());
		wait_drained();
		repeat (20) send_word(random_word());
	endtask

	task automatic test_back_to_back(input int n);
		gaps_on = 1'b0;
		repeat (n) send_word(random_word());
		gaps_on = 1'b1;
	endtask

	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(0, 99) < 29);

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		access_result_t exp_r;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected: status %0d address %h",
					$time, status, address);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", 64'(exp_r.status), 64'(status));
				check_field("address", exp_r.address, address);
				check_field("write_out", 64'(exp_r.write), 64'(write_out));
				check_field("space_out", 64'(exp_r.space), 64'(space_out));
				check_field("width_out", 64'(exp_r.width), 64'(width_out));
				check_field("count_out", 64'(exp_r.count), 64'(count_out));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_BARS; i++) begin
			bar_base_tbl[i] = '0;
			bar_size_tbl[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_windows();
		test_bar_loads();
		test_width_and_count();
		test_config_space();
		test_window_checks();
		test_random_traffic(250);
		test_drain_pause();
		test_back_to_back(120);
		test_random_traffic(110);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
